>>> rtl/core/ctsv_pkg.sv
package ctsv_pkg;

  // Deepest block nesting allowed; the 8-bit counter caps it at 255.
  localparam int unsigned MaxDepth = 255;
  localparam logic [7:0] DepthLimit = (MaxDepth < 255) ? 8'(MaxDepth) : 8'd255;

  // Result queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  localparam logic [7:0] ChOpen    = 8'h7B;  // {
  localparam logic [7:0] ChClose   = 8'h7D;  // }
  localparam logic [7:0] ChHash    = 8'h23;  // #
  localparam logic [7:0] ChSemi    = 8'h3B;  // ;
  localparam logic [7:0] ChSquote  = 8'h27;  // '
  localparam logic [7:0] ChDquote  = 8'h22;  // "
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChReturn  = 8'h0D;

  typedef enum logic [2:0] {
    LX_WS      = 3'd0,
    LX_WORD    = 3'd1,
    LX_SQ      = 3'd2,
    LX_DQ      = 3'd3,
    LX_COMMENT = 3'd4
  } lex_state_e;

  typedef enum logic [2:0] {
    PK_START = 3'd0,
    PK_WORD  = 3'd1,
    PK_OPEN  = 3'd2,
    PK_CLOSE = 3'd3,
    PK_END   = 3'd4
  } tok_kind_e;

  typedef enum logic [2:0] {
    EV_CHAR   = 3'd0,
    EV_TOKEND = 3'd1,
    EV_OPEN   = 3'd2,
    EV_CLOSE  = 3'd3,
    EV_STMT   = 3'd4,
    EV_ACCEPT = 3'd5,
    EV_ERROR  = 3'd6
  } event_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] char_value;
    logic       starts_statement;
    logic [7:0] depth;
    logic       last_of_item;
  } out_item_t;

  // One queue entry carries all results of one input beat.
  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      two;
  } q_entry_t;

  function automatic out_item_t mk_res(event_e ev, logic [7:0] ch, logic ss,
                                       logic [7:0] dep);
    out_item_t r;
    r.event_res        = ev;
    r.char_value       = ch;
    r.starts_statement = ss;
    r.depth            = dep;
    r.last_of_item     = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/core/ctsv_front.sv
module ctsv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ctsv_pkg::in_item_t in_item_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output ctsv_pkg::q_entry_t entry_o
);
  import ctsv_pkg::*;

  lex_state_e lx_q, lx_d;
  tok_kind_e  pk_q, pk_d;
  logic [7:0] dep_q, dep_d;
  logic       err_q, err_d;

  logic [7:0] c;
  logic       is_ws, is_term, accept;

  // between-token handling
  tok_kind_e  bt_pk, bt_pk_d;
  lex_state_e bt_lx;
  logic [7:0] bt_dep;
  logic       bt_valid, bt_err;
  out_item_t  bt_res;

  logic       n_any, n_two;
  out_item_t  r0, r1;
  tok_kind_e  eoi_pk;

  assign c       = in_item_i.byte_value;
  assign is_ws   = (c == ChSpace) || (c == ChTab) || (c == ChNewline) || (c == ChReturn);
  assign is_term = is_ws || (c == ChSemi) || (c == ChOpen) || (c == ChClose);
  assign in_ready_o = !q_full_i;
  assign accept  = in_valid_i && !q_full_i;

  always_comb begin
    bt_pk    = (lx_q == LX_WORD) ? PK_WORD : pk_q;
    bt_valid = 1'b1;
    bt_res   = mk_res(EV_ERROR, 8'd0, 1'b0, dep_q);
    bt_lx    = LX_WS;
    bt_pk_d  = bt_pk;
    bt_dep   = dep_q;
    bt_err   = 1'b0;
    if (c == ChOpen) begin
      if (bt_pk != PK_WORD || dep_q >= DepthLimit) begin
        bt_err = 1'b1;
      end else begin
        bt_dep  = dep_q + 8'd1;
        bt_pk_d = PK_OPEN;
        bt_res  = mk_res(EV_OPEN, 8'd0, 1'b0, bt_dep);
      end
    end else if (c == ChClose) begin
      if ((bt_pk != PK_END && bt_pk != PK_CLOSE) || dep_q == 8'd0) begin
        bt_err = 1'b1;
      end else begin
        bt_dep  = dep_q - 8'd1;
        bt_pk_d = PK_CLOSE;
        bt_res  = mk_res(EV_CLOSE, 8'd0, 1'b0, bt_dep);
      end
    end else if (c == ChSemi) begin
      if (bt_pk != PK_WORD) begin
        bt_err = 1'b1;
      end else begin
        bt_pk_d = PK_END;
        bt_res  = mk_res(EV_STMT, 8'd0, 1'b0, dep_q);
      end
    end else if (c == ChHash) begin
      bt_lx    = LX_COMMENT;
      bt_valid = 1'b0;
    end else if (c == ChDquote) begin
      bt_lx  = LX_DQ;
      bt_res = mk_res(EV_CHAR, c, 1'b0, dep_q);
    end else if (c == ChSquote) begin
      bt_lx  = LX_SQ;
      bt_res = mk_res(EV_CHAR, c, 1'b0, dep_q);
    end else if (is_ws) begin
      bt_valid = 1'b0;
    end else begin
      bt_lx  = LX_WORD;
      bt_res = mk_res(EV_CHAR, c, 1'b0, dep_q);
    end
  end

  always_comb begin
    lx_d  = lx_q;
    pk_d  = pk_q;
    dep_d = dep_q;
    err_d = err_q;
    n_any = 1'b0;
    n_two = 1'b0;
    r0    = mk_res(EV_ERROR, 8'd0, 1'b0, dep_q);
    r1    = mk_res(EV_ERROR, 8'd0, 1'b0, dep_q);
    eoi_pk = (lx_q == LX_WORD) ? PK_WORD : pk_q;
    if (err_q) begin
      n_any = 1'b1;
    end else if (in_item_i.end_of_input) begin
      n_any = 1'b1;
      if (lx_q == LX_SQ || lx_q == LX_DQ) begin
        err_d = 1'b1;
      end else begin
        if (lx_q == LX_WORD) begin
          // open word is closed first; the end check then fails
          r0    = mk_res(EV_TOKEND, 8'd0, pk_q != PK_WORD, dep_q);
          n_two = 1'b1;
          lx_d  = LX_WS;
          pk_d  = PK_WORD;
          err_d = 1'b1;
        end else if ((eoi_pk == PK_START || eoi_pk == PK_END || eoi_pk == PK_CLOSE) &&
                     dep_q == 8'd0) begin
          lx_d  = LX_WS;
          pk_d  = PK_START;
          dep_d = 8'd0;
          r0    = mk_res(EV_ACCEPT, 8'd0, 1'b0, 8'd0);
        end else begin
          err_d = 1'b1;
        end
      end
    end else begin
      unique case (lx_q)
        LX_WORD: begin
          if (is_term) begin
            r0    = mk_res(EV_TOKEND, 8'd0, pk_q != PK_WORD, dep_q);
            n_any = 1'b1;
            n_two = bt_valid || bt_err;
            r1    = bt_res;
            lx_d  = bt_lx;
            pk_d  = bt_pk_d;
            dep_d = bt_dep;
            err_d = bt_err;
          end else begin
            n_any = 1'b1;
            r0    = mk_res(EV_CHAR, c, 1'b0, dep_q);
          end
        end
        LX_SQ, LX_DQ: begin
          n_any = 1'b1;
          r0    = mk_res(EV_CHAR, c, 1'b0, dep_q);
          if ((lx_q == LX_SQ && c == ChSquote) || (lx_q == LX_DQ && c == ChDquote)) begin
            n_two = 1'b1;
            r1    = mk_res(EV_TOKEND, 8'd0, pk_q != PK_WORD, dep_q);
            pk_d  = PK_WORD;
            lx_d  = LX_WS;
          end
        end
        LX_COMMENT: begin
          if (c == ChNewline || c == ChReturn) begin
            lx_d = LX_WS;
          end
        end
        default: begin
          n_any = bt_valid || bt_err;
          r0    = bt_res;
          lx_d  = bt_lx;
          pk_d  = bt_pk_d;
          dep_d = bt_dep;
          err_d = bt_err;
        end
      endcase
    end
    r0.last_of_item = !n_two;
    r1.last_of_item = 1'b1;
  end

  assign push_o        = accept && n_any;
  assign entry_o.first  = r0;
  assign entry_o.second = r1;
  assign entry_o.two    = n_two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q  <= LX_WS;
      pk_q  <= PK_START;
      dep_q <= 8'd0;
      err_q <= 1'b0;
    end else if (accept) begin
      lx_q  <= lx_d;
      pk_q  <= pk_d;
      dep_q <= dep_d;
      err_q <= err_d;
    end
  end

endmodule

>>> rtl/core/ctsv_queue.sv
module ctsv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ctsv_pkg::q_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ctsv_pkg::q_entry_t head_o
);
  import ctsv_pkg::*;

  q_entry_t          mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QPtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/ctsv_back.sv
module ctsv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  ctsv_pkg::q_entry_t  q_head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctsv_pkg::out_item_t out_item_o
);
  import ctsv_pkg::*;

  logic      out_valid_q, sec_valid_q;
  out_item_t out_q, sec_q;
  logic      slot_free;

  // output slot takes a new result when empty or being drained
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = slot_free && !sec_valid_q && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (slot_free) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        out_valid_q <= !q_empty_i;
        sec_valid_q <= !q_empty_i && q_head_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (sec_valid_q) begin
        out_q <= sec_q;
      end else if (!q_empty_i) begin
        out_q <= q_head_i.first;
        sec_q <= q_head_i.second;
      end
    end
  end

endmodule

>>> rtl/core/config_token_stream_validator_top.sv
// Streaming lexer and grammar check for a block-structured configuration
// text. Feed the text one byte per beat, then one beat with end_of_input set.
// Each input beat yields zero, one or two result beats (token character,
// token end, block open/close, statement end, accepted, error); the last
// result of a beat carries last_of_item. The input side takes one byte per
// cycle while the queue is not full: the front lexer classifies a byte
// combinationally and drops its results into a four-entry queue. The back
// side hands out one result per cycle through an output register while
// out_ready_i is high, so a byte that ends a token and also gives a second
// event (';', '{', '}', closing quote, end after a word) yields two results;
// the queue soaks that up and in_ready_o drops only when it fills. The
// first result of a byte is stored in the queue and then in the output
// register before it is valid on the output. Once an error is reported
// every later beat returns one error result until reset. Block depth is
// limited to MaxDepth in the package (at most 255).
module config_token_stream_validator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ctsv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctsv_pkg::out_item_t out_item_o
);
  import ctsv_pkg::*;

  logic     q_full, q_empty, push, pop;
  q_entry_t entry, head;

  ctsv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  ctsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  ctsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/core/ctsv_checker.sv
module ctsv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ctsv_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ctsv_pkg::out_item_t out_item_o
);
  import ctsv_pkg::*;

  // stalled input beat stays up
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input beat dropped while stalled");

  // stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result beat dropped while stalled");

  // statement-start flag only on token end
  a_ss_tokend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.starts_statement |-> out_item_o.event_res == EV_TOKEND)
    else $error("starts_statement outside token end");

  // acceptance leaves no open block
  a_accept_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res == EV_ACCEPT |-> out_item_o.depth == 8'd0)
    else $error("accept with open block");

  // error is sticky
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.event_res == EV_ERROR |=>
      !out_valid_o || out_item_o.event_res == EV_ERROR)
    else $error("result after error is not an error");

endmodule

bind config_token_stream_validator_top ctsv_checker u_ctsv_checker (.*);
